FILE: design/rpce_pkg.sv
// Shared types, register codes and color helpers for the RGB555 pixel color effect.
`timescale 1ns / 1ps

package rpce_pkg;

  localparam int unsigned PIXEL_W = 16;
  localparam int unsigned CH_W    = 5;

  localparam logic [CH_W-1:0] CH_MAX           = 5'd31;
  localparam logic [CH_W-1:0] DARK_LIMIT       = 5'd17;
  localparam logic [CH_W-1:0] TINT_WEAK_BASE   = 5'd21;
  localparam logic [CH_W-1:0] TINT_STRONG_BASE = 5'd23;

  localparam int unsigned TRANSP_BIT = 15;

  typedef enum logic [1:0] {
    REG_EFFECT_MODE     = 2'd0,
    REG_TINT_SEED       = 2'd1,
    REG_BRIGHTEN_AMOUNT = 2'd2,
    REG_CAP_AMOUNT      = 2'd3
  } cfg_reg_t;

  localparam logic [2:0] MODE_GRAY     = 3'd0;
  localparam logic [2:0] MODE_INVERT   = 3'd1;
  localparam logic [2:0] MODE_BW       = 3'd2;
  localparam logic [2:0] MODE_TINT     = 3'd3;
  localparam logic [2:0] MODE_BRIGHTEN = 3'd4;
  localparam logic [2:0] MODE_CAP      = 3'd5;

  localparam logic [2:0] HUE_TEAL   = 3'd0;
  localparam logic [2:0] HUE_YELLOW = 3'd1;
  localparam logic [2:0] HUE_PURPLE = 3'd2;
  localparam logic [2:0] HUE_RED    = 3'd3;
  localparam logic [2:0] HUE_BLUE   = 3'd4;

  typedef struct packed {
    logic [2:0]      effect_mode;
    logic [7:0]      tint_seed;
    logic [CH_W-1:0] brighten_amount;
    logic [CH_W-1:0] cap_amount;
  } cfg_t;

  function automatic logic [14:0] pack_rgb(input logic [CH_W-1:0] r,
                                           input logic [CH_W-1:0] g,
                                           input logic [CH_W-1:0] b);
    return {b, g, r};
  endfunction

  // seed / 18 by reciprocal (57 / 1024), exact over the 8-bit range
  function automatic logic [14:0] tint_color(input logic [7:0] seed);
    logic [13:0]     prod;
    logic [3:0]      q18;
    logic [7:0]      m18_full;
    logic [4:0]      m18;
    logic [1:0]      strength;
    logic [2:0]      hue;
    logic [CH_W-1:0] lvl_lo;
    logic [CH_W-1:0] lvl_hi;
    logic [14:0]     color;
    prod     = 14'(seed) * 14'd57;
    q18      = prod[13:10];
    m18_full = seed - (8'(q18) * 8'd18);
    m18      = m18_full[4:0];
    if (m18 >= 5'd12) begin
      strength = 2'd2;
      hue      = 3'(m18 - 5'd12);
    end else if (m18 >= 5'd6) begin
      strength = 2'd1;
      hue      = 3'(m18 - 5'd6);
    end else begin
      strength = 2'd0;
      hue      = m18[2:0];
    end
    lvl_lo = TINT_WEAK_BASE - 5'(strength);
    lvl_hi = TINT_STRONG_BASE - 5'(strength);
    case (hue)
      HUE_TEAL:   color = pack_rgb('0, lvl_lo, lvl_lo);
      HUE_YELLOW: color = pack_rgb(lvl_lo, lvl_lo, '0);
      HUE_PURPLE: color = pack_rgb(lvl_lo, '0, lvl_lo);
      HUE_RED:    color = pack_rgb(lvl_hi, '0, '0);
      HUE_BLUE:   color = pack_rgb('0, '0, lvl_hi);
      default:    color = pack_rgb('0, lvl_hi, '0);
    endcase
    return color;
  endfunction

endpackage

FILE: design/rgb555_pixel_color_effect.sv
// Top level of the RGB555 pixel color effect: input stage, effect logic, result stage.
//
//   Channel  Dir  Handshake            Payload
//   in_      in   in_valid/in_ready    in_pixel_in[15:0]
//   out_     out  out_valid/out_ready  out_pixel_out[15:0]
//   cfg_     in   cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[7:0]
//
// One pixel per cycle sustained while out_ready stays high; a pixel passes through the input
// register, the effect logic and the result register before it leaves.
// Synchronous active-low reset clears both stage valids and the effect registers;
// the pixel registers keep their contents.
// The input stage keeps taking beats while a result waits, until both stages hold data.
`timescale 1ns / 1ps

module rgb555_pixel_color_effect (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rpce_pkg::PIXEL_W-1:0] in_pixel_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rpce_pkg::PIXEL_W-1:0] out_pixel_out,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [7:0]                   cfg_data
);
  import rpce_pkg::*;

  cfg_t               cfg;
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic [PIXEL_W-1:0] s1_pixel_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [PIXEL_W-1:0] out_pixel_r;
  logic [PIXEL_W-1:0] effect_result;
  logic               out_free;
  logic               s1_move;
  logic               in_take;

  rpce_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpce_effect u_effect (
    .pixel  (s1_pixel_r),
    .cfg    (cfg),
    .result (effect_result)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_take  = in_valid && in_ready;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_move);
  assign out_valid_nxt = s1_move || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pixel_r <= in_pixel_in;
    end
    if (s1_move) begin
      out_pixel_r <= effect_result;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free stage");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("advanced beat did not reach result stage");

  a_transp_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && s1_pixel_r[TRANSP_BIT]) |=> (out_pixel_r == $past(s1_pixel_r)))
    else $error("transparent pixel altered");

  a_opaque_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && !s1_pixel_r[TRANSP_BIT]) |=> !out_pixel_r[TRANSP_BIT])
    else $error("opaque pixel left with transparent flag");

endmodule

FILE: design/rpce_cfg_regs.sv
// Configuration register file for the pixel color effect.
`timescale 1ns / 1ps

module rpce_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output rpce_pkg::cfg_t     cfg
);
  import rpce_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EFFECT_MODE:     cfg_nxt.effect_mode     = cfg_data[2:0];
        REG_TINT_SEED:       cfg_nxt.tint_seed       = cfg_data;
        REG_BRIGHTEN_AMOUNT: cfg_nxt.brighten_amount = cfg_data[CH_W-1:0];
        REG_CAP_AMOUNT:      cfg_nxt.cap_amount      = cfg_data[CH_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/rpce_effect.sv
// Per-pixel effect logic: computes the result pixel from one input pixel.
`timescale 1ns / 1ps

module rpce_effect (
  input  logic [rpce_pkg::PIXEL_W-1:0] pixel,
  input  rpce_pkg::cfg_t               cfg,
  output logic [rpce_pkg::PIXEL_W-1:0] result
);
  import rpce_pkg::*;

  logic [CH_W-1:0] r;
  logic [CH_W-1:0] g;
  logic [CH_W-1:0] b;
  logic            dark;
  logic [6:0]      sum;
  logic [12:0]     gray_prod;
  logic [CH_W-1:0] gray_v;
  logic [CH_W:0]   bright_sum;
  logic [CH_W-1:0] bright_v;
  logic [CH_W-1:0] cap_v;
  logic [14:0]     white;

  assign r     = pixel[4:0];
  assign g     = pixel[9:5];
  assign b     = pixel[14:10];
  assign dark  = (r < DARK_LIMIT) && (g < DARK_LIMIT) && (b < DARK_LIMIT);
  assign white = pack_rgb(CH_MAX, CH_MAX, CH_MAX);

  // divide by three via 43 / 128, exact for sums up to 93
  assign sum       = 7'(r) + 7'(g) + 7'(b);
  assign gray_prod = 13'(sum) * 13'd43;
  assign gray_v    = gray_prod[11:7];

  assign bright_sum = {1'b0, r} + {1'b0, cfg.brighten_amount};
  assign bright_v   = bright_sum[CH_W] ? CH_MAX : bright_sum[CH_W-1:0];

  assign cap_v = (r > (CH_MAX - cfg.cap_amount)) ? (CH_MAX - (cfg.cap_amount >> 1)) : r;

  always_comb begin
    result = pixel;
    if (!pixel[TRANSP_BIT]) begin
      case (cfg.effect_mode)
        MODE_GRAY:     result = {1'b0, pack_rgb(gray_v, gray_v, gray_v)};
        MODE_INVERT:   result = {1'b0, pack_rgb(CH_MAX - r, CH_MAX - g, CH_MAX - b)};
        MODE_BW:       result = {1'b0, dark ? 15'd0 : white};
        MODE_TINT:     result = {1'b0, dark ? tint_color(cfg.tint_seed) : white};
        MODE_BRIGHTEN: result = {1'b0, pack_rgb(bright_v, bright_v, bright_v)};
        MODE_CAP:      result = {1'b0, pack_rgb(cap_v, cap_v, cap_v)};
        default:       result = pixel;
      endcase
    end
  end

endmodule

FILE: tb/rpce_effect_checker.sv
// Pixel effect checker: predicts each output pixel from the input beats and register writes.
`timescale 1ns / 1ps

module rpce_effect_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [rpce_pkg::PIXEL_W-1:0] in_pixel_in,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [rpce_pkg::PIXEL_W-1:0] out_pixel_out,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [7:0]                   cfg_data,
  output int                           fail_count,
  output int                           pending_cnt,
  output int                           checked_cnt
);
  import rpce_pkg::*;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [PIXEL_W-1:0] want;
  } pixel_pair_t;

  cfg_t        settings;
  pixel_pair_t pending_pixels[$];

  function automatic logic [PIXEL_W-1:0] color_effect(input logic [PIXEL_W-1:0] px,
                                                      input cfg_t c);
    logic [CH_W-1:0]    r;
    logic [CH_W-1:0]    g;
    logic [CH_W-1:0]    b;
    logic [CH_W-1:0]    v;
    logic [CH_W-1:0]    lo_lvl;
    logic [CH_W-1:0]    hi_lvl;
    logic [6:0]         total;
    logic [5:0]         bright;
    logic [2:0]         hue;
    logic [1:0]         strength;
    logic               dark;
    logic [PIXEL_W-1:0] res;
    r    = px[4:0];
    g    = px[9:5];
    b    = px[14:10];
    dark = (r < DARK_LIMIT) && (g < DARK_LIMIT) && (b < DARK_LIMIT);
    res  = px;
    if (!px[TRANSP_BIT]) begin
      case (c.effect_mode)
        MODE_GRAY: begin
          total = 7'(r) + 7'(g) + 7'(b);
          v     = 5'(total / 7'd3);
          res   = {1'b0, v, v, v};
        end
        MODE_INVERT: res = {1'b0, CH_MAX - b, CH_MAX - g, CH_MAX - r};
        MODE_BW:     res = dark ? '0 : {1'b0, CH_MAX, CH_MAX, CH_MAX};
        MODE_TINT: begin
          if (dark) begin
            hue      = 3'(c.tint_seed % 8'd6);
            strength = 2'((c.tint_seed / 8'd6) % 8'd3);
            lo_lvl   = TINT_WEAK_BASE - 5'(strength);
            hi_lvl   = TINT_STRONG_BASE - 5'(strength);
            case (hue)
              HUE_TEAL:   res = {1'b0, lo_lvl, lo_lvl, 5'd0};
              HUE_YELLOW: res = {1'b0, 5'd0, lo_lvl, lo_lvl};
              HUE_PURPLE: res = {1'b0, lo_lvl, 5'd0, lo_lvl};
              HUE_RED:    res = {1'b0, 5'd0, 5'd0, hi_lvl};
              HUE_BLUE:   res = {1'b0, hi_lvl, 5'd0, 5'd0};
              default:    res = {1'b0, 5'd0, hi_lvl, 5'd0};
            endcase
          end else begin
            res = {1'b0, CH_MAX, CH_MAX, CH_MAX};
          end
        end
        MODE_BRIGHTEN: begin
          bright = 6'(r) + 6'(c.brighten_amount);
          v      = (bright > 6'(CH_MAX)) ? CH_MAX : bright[4:0];
          res    = {1'b0, v, v, v};
        end
        MODE_CAP: begin
          v   = (r > CH_MAX - c.cap_amount) ? CH_MAX - (c.cap_amount >> 1) : r;
          res = {1'b0, v, v, v};
        end
        default: res = px;
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_pair_t head;
    if (!rst_n) begin
      settings = '0;
      pending_pixels.delete();
      pending_cnt <= 0;
      fail_count  <= 0;
      checked_cnt <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_EFFECT_MODE:     settings.effect_mode = cfg_data[2:0];
          REG_TINT_SEED:       settings.tint_seed = cfg_data;
          REG_BRIGHTEN_AMOUNT: settings.brighten_amount = cfg_data[4:0];
          REG_CAP_AMOUNT:      settings.cap_amount = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pending_pixels.push_back({in_pixel_in, color_effect(in_pixel_in, settings)});
      end
      if (out_valid && out_ready) begin
        checked_cnt <= checked_cnt + 1;
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel_out %h with no pixel pending", $time, out_pixel_out);
          fail_count <= fail_count + 1;
        end else begin
          head = pending_pixels.pop_front();
          if (out_pixel_out !== head.want) begin
            $display("%0t: pixel_out mismatch for pixel_in %h: expected %h, got %h",
                     $time, head.pixel, head.want, out_pixel_out);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_cnt <= pending_pixels.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top: drives pixels and register writes into the color effect and reports the verdict.
`timescale 1ns / 1ps

module tb_top;
  import rpce_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SEGMENTS     = 40;
  localparam int unsigned SEG_PIXELS   = 50;
  localparam int unsigned PRESS_PIXELS = 60;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [PIXEL_W-1:0] in_pixel_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PIXEL_W-1:0] out_pixel_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [7:0]         cfg_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned pixels_sent = 0;
  int unsigned reg_writes = 0;
  int          fail_count;
  int          pending_cnt;
  int          checked_cnt;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb555_pixel_color_effect i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  rpce_effect_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_cnt   (pending_cnt),
    .checked_cnt   (checked_cnt)
  );

  // hold off the receiver once for a long stretch, otherwise stall at random
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d pixels pending", $time, pending_cnt);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [PIXEL_W-1:0] random_pixel();
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic            clear;
    case ($urandom_range(0, 3))
      0: begin
        r = 5'($urandom_range(0, 16));
        g = 5'($urandom_range(0, 16));
        b = 5'($urandom_range(0, 16));
      end
      1: begin
        r = 5'($urandom_range(15, 18));
        g = 5'($urandom_range(15, 18));
        b = 5'($urandom_range(15, 18));
      end
      default: begin
        r = 5'($urandom_range(0, 31));
        g = 5'($urandom_range(0, 31));
        b = 5'($urandom_range(0, 31));
      end
    endcase
    clear = ($urandom_range(0, 3) == 0);
    return {clear, b, g, r};
  endfunction

  function automatic logic [7:0] pick_amount();
    logic [4:0] amt;
    case ($urandom_range(0, 4))
      0:       amt = 5'd0;
      1:       amt = 5'd31;
      default: amt = 5'($urandom_range(0, 31));
    endcase
    return {3'($urandom_range(0, 7)), amt};
  endfunction

  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    in_valid    <= 1'b1;
    in_pixel_in <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_cnt == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned seg;
    int unsigned k;
    logic [2:0]  mode;
    logic [7:0]  seed;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: gray
    send_pixel(16'h0000);
    send_pixel(16'h7FFF);
    send_pixel(16'hFFFF);
    send_pixel(16'h8000);
    send_pixel(16'h4210);
    drain();
    write_reg(REG_EFFECT_MODE, {5'd0, MODE_INVERT});
    send_pixel(16'h001F);
    send_pixel(16'h5555);
    drain();
    write_reg(REG_EFFECT_MODE, {5'd0, MODE_BW});
    send_pixel(16'h4210);
    send_pixel(16'h0011);
    send_pixel(16'h0220);
    send_pixel(16'h4400);
    drain();
    write_reg(REG_TINT_SEED, 8'hFF);
    write_reg(REG_EFFECT_MODE, {5'd0, MODE_TINT});
    send_pixel(16'h0000);
    send_pixel(16'h7FFF);
    drain();
    write_reg(REG_BRIGHTEN_AMOUNT, 8'h1F);
    write_reg(REG_EFFECT_MODE, {5'd0, MODE_BRIGHTEN});
    send_pixel(16'h001F);
    send_pixel(16'h0000);
    drain();
    write_reg(REG_CAP_AMOUNT, 8'h1F);
    write_reg(REG_EFFECT_MODE, {5'd0, MODE_CAP});
    send_pixel(16'h0011);
    send_pixel(16'h0010);
    drain();
    write_reg(REG_EFFECT_MODE, 8'hFE);
    send_pixel(16'h1234);
    drain();
    write_reg(REG_EFFECT_MODE, 8'hFF);
    send_pixel(16'h2AAA);
    drain();

    // fill the pipe against a held-off receiver
    write_reg(REG_EFFECT_MODE, {5'd0, MODE_GRAY});
    hold_req <= 1'b1;
    for (k = 0; k < PRESS_PIXELS; k++) send_pixel(random_pixel());
    drain();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 83;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 83;
        end
        default: begin
          send_idle_pct  <= 18;
          recv_stall_pct <= 18;
        end
      endcase
      mode = ($urandom_range(0, 99) < 10) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
      case ($urandom_range(0, 9))
        0:       seed = 8'h00;
        1:       seed = 8'hFF;
        default: seed = 8'($urandom_range(0, 255));
      endcase
      write_reg(REG_EFFECT_MODE, {5'($urandom_range(0, 31)), mode});
      write_reg(REG_TINT_SEED, seed);
      write_reg(REG_BRIGHTEN_AMOUNT, pick_amount());
      write_reg(REG_CAP_AMOUNT, pick_amount());
      for (k = 0; k < SEG_PIXELS; k++) send_pixel(random_pixel());
      drain();
    end

    $display("Run sent %0d pixels across %0d register writes, all eight mode codes,",
             pixels_sent, reg_writes);
    $display("four idle mixes and a %0d-cycle receiver hold-off; %0d results compared.",
             HOLD_CYCLES, checked_cnt);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
